FILE: rtl/core/lru_pkg.sv
// shared constants and types for the lru page replacement unit
package lru_pkg;

  localparam int MAX_FRAMES        = 16;
  localparam int PAGE_BITS         = 20;
  localparam int IDX_W             = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W             = $clog2(MAX_FRAMES + 1);
  localparam int LIMIT_W           = 5;
  localparam int OCC_W             = 5;
  localparam int CMP_W             = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int RESET_FRAME_LIMIT = 6;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/lru_ctrl.sv
// controller state machine: accepts one item, then runs one lookup and update
module lru_ctrl import lru_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        // wait here until the result register can take the new item
        cmd.execute = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/lru_datapath.sv
// datapath: recency stack, parallel tag compare, stack shift and result register
module lru_datapath import lru_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  input  logic [PAGE_BITS-1:0] in_page_number,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic               out_evicted_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [OCC_W-1:0]   out_occupied_frames
);

  page_t              stack_r [MAX_FRAMES];
  page_t              stack_nxt [MAX_FRAMES];
  page_t              page_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic               out_ev_r;
  page_t              out_ev_page_r;
  logic [OCC_W-1:0]   out_occ_r;

  logic [CMP_W-1:0]   lim_eff;
  logic [CMP_W-1:0]   count_ext;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   last_idx;
  logic               hit;
  logic [IDX_W-1:0]   hit_pos;
  logic               evict;
  logic [IDX_W-1:0]   upto;

  // zero limit means one frame, anything above the stack depth saturates
  always_comb begin
    if (limit_r == '0) begin
      lim_eff = CMP_W'(1);
    end else if (CMP_W'(limit_r) > CMP_W'(MAX_FRAMES)) begin
      lim_eff = CMP_W'(MAX_FRAMES);
    end else begin
      lim_eff = CMP_W'(limit_r);
    end
  end

  assign count_ext = CMP_W'(count_r);
  assign cnt_m1    = count_r - CNT_W'(1);
  assign last_idx  = cnt_m1[IDX_W-1:0];

  // parallel compare over resident entries, lowest matching position wins
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < count_r) && (stack_r[i] == page_r)) begin
        hit     = 1'b1;
        hit_pos = IDX_W'(i);
      end
    end
  end

  assign evict = !hit && (count_ext >= lim_eff);

  always_comb begin
    if (hit) begin
      upto = hit_pos;
    end else if (evict) begin
      upto = last_idx;
    end else begin
      upto = count_r[IDX_W-1:0];
    end
  end

  always_comb begin
    stack_nxt[0] = page_r;
    for (int i = 1; i < MAX_FRAMES; i++) begin
      stack_nxt[i] = (IDX_W'(i) <= upto) ? stack_r[i-1] : stack_r[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (!hit && !evict) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      limit_r     <= LIMIT_W'(RESET_FRAME_LIMIT);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.execute) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= in_page_number;
    end
    if (cmd.execute) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        stack_r[i] <= stack_nxt[i];
      end
      out_hit_r     <= hit;
      out_ev_r      <= evict;
      out_ev_page_r <= evict ? stack_r[last_idx] : '0;
      out_occ_r     <= OCC_W'(count_nxt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_evicted_valid   = out_ev_r;
  assign out_evicted_page    = out_ev_page_r;
  assign out_occupied_frames = out_occ_r;

endmodule

FILE: rtl/core/lru_page_replacement_unit.sv
// lru page replacement unit: controller plus recency stack datapath
// result: the item is captured on acceptance, then the execute state registers the result
// once the result register is free; one item at a time (capture, then compare and stack shift)
// a stalled result register holds the controller in its execute state
// reset (rst_n low, synchronous): stack empty, frame limit 6, no result pending
module lru_page_replacement_unit import lru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] in_page_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic                 out_evicted_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [OCC_W-1:0]     out_occupied_frames,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lru_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_page_number      (in_page_number),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_evicted_valid   (out_evicted_valid),
    .out_evicted_page    (out_evicted_page),
    .out_occupied_frames (out_occupied_frames)
  );

endmodule
